// File: hw/rtl/wlc_pkg.sv
// Shared types and constants for the window lifter controller.
// Depends on nothing; used by every module of the block.
`default_nettype none

package wlc_pkg;

	localparam int unsigned LEVEL_W = 4;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned LOCK_W = 6;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PINCH_CONFIRM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL = 3'd4;

	localparam logic [CNT_W-1:0] RST_PRESS_THRESHOLD = 4'd5;
	localparam logic [CNT_W-1:0] RST_STEP_PERIOD = 4'd4;
	localparam logic [CNT_W-1:0] RST_PINCH_CONFIRM = 4'd1;
	localparam logic [LOCK_W-1:0] RST_LOCKOUT_PERIOD = 6'd50;
	localparam logic [LEVEL_W-1:0] RST_TOP_LEVEL = 4'd10;

	localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

	typedef enum logic [7:0] {
		M_IDLE     = 8'b0000_0001,
		M_TIME_UP  = 8'b0000_0010,
		M_TIME_DN  = 8'b0000_0100,
		M_ONE_UP   = 8'b0000_1000,
		M_MAN_UP   = 8'b0001_0000,
		M_ONE_DN   = 8'b0010_0000,
		M_MAN_DN   = 8'b0100_0000,
		M_REVERSE  = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic up_button;
		logic down_button;
		logic pinch_sensor;
	} in_word_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] window_level;
		logic               up_led;
		logic               down_led;
		logic               pinch_led;
		logic               locked_out;
	} out_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]   press_threshold;
		logic [CNT_W-1:0]   step_period;
		logic [CNT_W-1:0]   pinch_confirm;
		logic [LOCK_W-1:0]  lockout_period;
		logic [LEVEL_W-1:0] top_level;
	} cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/wlc_cfg.sv
// Configuration register file of the window lifter controller.
// Depends on wlc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module wlc_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [wlc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [wlc_pkg::CFG_DATA_W-1:0]  wr_data,
	output wlc_pkg::cfg_t                        cfg
);

	wlc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_threshold <= wlc_pkg::RST_PRESS_THRESHOLD;
			cfg_q.step_period <= wlc_pkg::RST_STEP_PERIOD;
			cfg_q.pinch_confirm <= wlc_pkg::RST_PINCH_CONFIRM;
			cfg_q.lockout_period <= wlc_pkg::RST_LOCKOUT_PERIOD;
			cfg_q.top_level <= wlc_pkg::RST_TOP_LEVEL;
		end else if (wr_en) begin
			unique case (wr_index)
				wlc_pkg::REG_PRESS_THRESHOLD: cfg_q.press_threshold <= wr_data[3:0];
				wlc_pkg::REG_STEP_PERIOD: cfg_q.step_period <= wr_data[3:0];
				wlc_pkg::REG_PINCH_CONFIRM: cfg_q.pinch_confirm <= wr_data[3:0];
				wlc_pkg::REG_LOCKOUT_PERIOD: cfg_q.lockout_period <= wr_data;
				wlc_pkg::REG_TOP_LEVEL: cfg_q.top_level <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/wlc_core.sv
// Window state machine: level, mode and tick counters, one update per word.
// Depends on wlc_pkg for mode_t, in_word_t, out_word_t and cfg_t.
`default_nettype none

module wlc_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire wlc_pkg::in_word_t in_word,
	input  wire wlc_pkg::cfg_t     cfg,
	output wlc_pkg::out_word_t result
);

	wlc_pkg::mode_t                mode_q, mode_d;
	logic [wlc_pkg::LEVEL_W-1:0]   level_q, level_d;
	logic [wlc_pkg::CNT_W-1:0]     hold_q, hold_d;
	logic [wlc_pkg::CNT_W-1:0]     step_q, step_d;
	logic [wlc_pkg::CNT_W-1:0]     pinch_q, pinch_d;
	logic [wlc_pkg::LOCK_W-1:0]    lock_q, lock_d;

	logic [wlc_pkg::CNT_W-1:0]     step_inc;
	logic [wlc_pkg::CNT_W-1:0]     step_per;
	logic                          step_hit;
	logic [wlc_pkg::CNT_W-1:0]     step_adv;
	logic [wlc_pkg::CNT_W-1:0]     hold_inc;
	logic [wlc_pkg::CNT_W-1:0]     pinch_new;
	logic [wlc_pkg::LEVEL_W-1:0]   level_up;
	logic [wlc_pkg::LEVEL_W-1:0]   level_dn;
	logic                          held;

	assign step_inc = (step_q != wlc_pkg::CNT_MAX) ? step_q + 4'd1 : step_q;
	assign step_per = (cfg.step_period == '0) ? 4'd1 : cfg.step_period;
	assign step_hit = step_inc >= step_per;
	assign step_adv = step_hit ? '0 : step_inc;
	assign hold_inc = (hold_q != wlc_pkg::CNT_MAX) ? hold_q + 4'd1 : hold_q;
	assign pinch_new = !in_word.pinch_sensor ? '0 :
		((pinch_q != wlc_pkg::CNT_MAX) ? pinch_q + 4'd1 : pinch_q);
	assign level_up = level_q + 4'd1;
	assign level_dn = level_q - 4'd1;
	assign held = (mode_q == wlc_pkg::M_TIME_UP) ? in_word.up_button : in_word.down_button;

	always_comb begin
		mode_d = mode_q;
		level_d = level_q;
		hold_d = hold_q;
		step_d = step_q;
		pinch_d = pinch_q;
		lock_d = lock_q;
		unique case (mode_q)
			wlc_pkg::M_IDLE: begin
				if (lock_q != '0) begin
					lock_d = lock_q - 6'd1;
				end else if (in_word.up_button) begin
					hold_d = 4'd1;
					step_d = '0;
					mode_d = (cfg.press_threshold <= 4'd1) ? wlc_pkg::M_MAN_UP
						: wlc_pkg::M_TIME_UP;
				end else if (in_word.down_button) begin
					hold_d = 4'd1;
					step_d = '0;
					mode_d = (cfg.press_threshold <= 4'd1) ? wlc_pkg::M_MAN_DN
						: wlc_pkg::M_TIME_DN;
				end
			end
			wlc_pkg::M_TIME_UP, wlc_pkg::M_TIME_DN: begin
				if (held) begin
					hold_d = hold_inc;
					if (hold_inc >= cfg.press_threshold) begin
						mode_d = (mode_q == wlc_pkg::M_TIME_UP) ? wlc_pkg::M_MAN_UP
							: wlc_pkg::M_MAN_DN;
						step_d = '0;
					end
				end else begin
					mode_d = (mode_q == wlc_pkg::M_TIME_UP) ? wlc_pkg::M_ONE_UP
						: wlc_pkg::M_ONE_DN;
					step_d = '0;
					pinch_d = '0;
				end
			end
			wlc_pkg::M_ONE_UP: begin
				if (level_q >= cfg.top_level) begin
					level_d = cfg.top_level;
					mode_d = wlc_pkg::M_IDLE;
					hold_d = '0;
					step_d = '0;
					pinch_d = '0;
				end else if (in_word.pinch_sensor && pinch_new >= cfg.pinch_confirm) begin
					mode_d = wlc_pkg::M_REVERSE;
					step_d = '0;
					pinch_d = '0;
				end else begin
					pinch_d = pinch_new;
					step_d = step_adv;
					if (step_hit) begin
						level_d = level_up;
						if (level_up >= cfg.top_level) begin
							mode_d = wlc_pkg::M_IDLE;
							hold_d = '0;
							step_d = '0;
							pinch_d = '0;
						end
					end
				end
			end
			wlc_pkg::M_MAN_UP: begin
				if (!in_word.up_button) begin
					mode_d = wlc_pkg::M_IDLE;
					hold_d = '0;
					step_d = '0;
					pinch_d = '0;
				end else if (level_q >= cfg.top_level) begin
					level_d = cfg.top_level;
					step_d = '0;
				end else begin
					step_d = step_adv;
					if (step_hit) begin
						level_d = level_up;
					end
				end
			end
			wlc_pkg::M_ONE_DN: begin
				if (level_q == '0) begin
					mode_d = wlc_pkg::M_IDLE;
					hold_d = '0;
					step_d = '0;
					pinch_d = '0;
				end else begin
					step_d = step_adv;
					if (step_hit) begin
						level_d = level_dn;
						if (level_dn == '0) begin
							mode_d = wlc_pkg::M_IDLE;
							hold_d = '0;
							step_d = '0;
							pinch_d = '0;
						end
					end
				end
			end
			wlc_pkg::M_MAN_DN: begin
				if (!in_word.down_button) begin
					mode_d = wlc_pkg::M_IDLE;
					hold_d = '0;
					step_d = '0;
					pinch_d = '0;
				end else if (level_q == '0) begin
					step_d = '0;
				end else begin
					step_d = step_adv;
					if (step_hit) begin
						level_d = level_dn;
					end
				end
			end
			wlc_pkg::M_REVERSE: begin
				if (level_q != '0) begin
					step_d = step_adv;
					if (step_hit) begin
						level_d = level_dn;
					end
				end
				if (level_d == '0) begin
					mode_d = wlc_pkg::M_IDLE;
					hold_d = '0;
					step_d = '0;
					pinch_d = '0;
					lock_d = cfg.lockout_period;
				end
			end
			default: begin
				mode_d = wlc_pkg::M_IDLE;
				hold_d = '0;
				step_d = '0;
				pinch_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= wlc_pkg::M_IDLE;
			level_q <= '0;
			hold_q <= '0;
			step_q <= '0;
			pinch_q <= '0;
			lock_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			level_q <= level_d;
			hold_q <= hold_d;
			step_q <= step_d;
			pinch_q <= pinch_d;
			lock_q <= lock_d;
		end
	end

	always_comb begin
		result.window_level = level_d;
		result.up_led = (mode_d == wlc_pkg::M_ONE_UP) || (mode_d == wlc_pkg::M_MAN_UP);
		result.down_led = (mode_d == wlc_pkg::M_ONE_DN) || (mode_d == wlc_pkg::M_MAN_DN);
		result.pinch_led = (mode_d == wlc_pkg::M_REVERSE);
		result.locked_out = (lock_d != '0);
	end

endmodule

`default_nettype wire

// File: hw/rtl/window_lifter_controller.sv
// Power window lifter controller: one-touch, manual and anti-pinch control per tick word.
// Each word passes the input register, then the result register. Throughput: one word
// per cycle unless out_stall holds the result; the state update is a single pass.
// Reset: arst_n clears the pipeline, returns the window state to idle at level 0
// and loads the configuration reset values. Depends on wlc_pkg, wlc_cfg, wlc_core.
`default_nettype none

module window_lifter_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire wlc_pkg::in_word_t               in_data,
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output wlc_pkg::out_word_t                   out_data,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [wlc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [wlc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	wlc_pkg::cfg_t      cfg;
	wlc_pkg::in_word_t  data_s1;
	logic               valid_s1;
	wlc_pkg::out_word_t result;
	wlc_pkg::out_word_t out_q;
	logic               out_valid_q;
	logic               advance;

	assign cfg_ready = 1'b1;

	wlc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	wlc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.in_word (data_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/wlc_checker.sv
// Port-level checks for the window lifter controller, bound to the top level.
// Depends on wlc_pkg for the word types.
`default_nettype none

module wlc_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         out_valid,
	input wire logic         out_stall,
	input wire wlc_pkg::out_word_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_led_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({out_data.up_led, out_data.down_led, out_data.pinch_led}))
		else $error("more than one motion LED lit");

	a_pinch_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pinch_led |-> !out_data.locked_out)
		else $error("reversal shown during lockout");

	a_move_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.up_led || out_data.down_led) |-> !out_data.locked_out)
		else $error("window moving during lockout");

endmodule

bind window_lifter_controller wlc_checker u_wlc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
